// ===== sv/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and codes of the first-fit heap allocator
// Item payload structs, command and status codes, register indexes and
// register reset values.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int FIELD_W    = 24;
    localparam int STATUS_W   = 3;
    localparam int HDR_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_IGNORED   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_HEAP   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 2'd1;

    localparam logic [FIELD_W-1:0] HEAP_LIMIT_RST   = 24'd65536;
    localparam logic [HDR_W-1:0]   HEADER_BYTES_RST = 8'd12;

    typedef struct packed {
        logic               cmd;
        logic [FIELD_W-1:0] request_size;
        logic [FIELD_W-1:0] payload_address;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  granted_address;
        logic [STATUS_W-1:0] status;
        logic                reused;
    } out_item_t;

endpackage

// ===== sv/first_fit_heap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit: first-fit heap allocator with a break pointer
// Block table in a memory, scanned in address order by a small microcoded
// sequencer; appends at top or reuses a free block; free pops last or marks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready/s_data carries one item: an allocate
//   (cmd 0, request_size) or a free (cmd 1, payload_address). Every item
//   yields exactly one result item on m_valid/m_ready/m_data: the granted
//   payload offset, a status code and a reuse flag.
//   cfg_valid/cfg_ready/cfg_index/cfg_data writes heap_limit (index 0) or
//   header_bytes (index 1); other indexes are dropped. cfg_ready is always
//   high; write only while the block is idle.
// Timing:
//   A null free or zero-size allocate skips the table scan and is ignored.
//   Any other item reads the block table one entry per cycle, stopping at
//   the first match. One item is in work at a time; s_ready is high only
//   while the sequencer sits at its idle step.
// Reset:
//   aresetn (synchronous, active low) empties the table, zeroes the heap top,
//   loads the register defaults and drops any pending result. No clearing
//   pass is needed: only entries below the entry count are ever read.
// Stall:
//   The result sits in an output register. A new item is accepted while it
//   waits; the sequencer holds at its emit step until the register frees.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit #(
    parameter int MAX_BLOCKS = 64,
    parameter int ADDR_BITS  = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  ffha_pkg::in_item_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output ffha_pkg::out_item_t                  m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ffha_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int FW     = ffha_pkg::FIELD_W;
    localparam int HW     = ffha_pkg::HDR_W;
    localparam int AW     = ADDR_BITS;
    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int CW_W   = (AW > FW) ? AW : FW;   // compare width
    localparam int NT_W   = CW_W + 2;              // top + header + size
    localparam int DROP_W = FW + 1;                // header + size
    localparam int UPC_W  = 5;

    // ------------------------------------------------------------------
    // Microcode format
    // ------------------------------------------------------------------
    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_ACCEPT, OP_INIT, OP_SCAN, OP_CALC_TOP, OP_APPEND, OP_REUSE,
        OP_FREE_EVAL, OP_FREE_APPLY, OP_RES_IGNORE, OP_RES_NOHEAP, OP_RES_FULL,
        OP_RES_UNKNOWN, OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        COND_ALWAYS, COND_ACCEPTED, COND_NULL, COND_SCAN_DONE, COND_HIT,
        COND_IS_FREE, COND_OVER_LIMIT, COND_TABLE_FULL, COND_OUT_FREE
    } cond_t;

    // NEXT: fall through. BRANCH: cond ? target : fall through.
    // WAIT: cond ? target : hold on this step.
    typedef enum logic [1:0] {SEQ_NEXT, SEQ_BRANCH, SEQ_WAIT} seq_t;

    typedef struct packed {
        op_t   op;
        seq_t  seq;
        cond_t cond;
        upc_t  target;
    } ucode_t;

    localparam upc_t U_IDLE       = 5'd0;
    localparam upc_t U_DISPATCH   = 5'd1;
    localparam upc_t U_SCAN       = 5'd2;
    localparam upc_t U_SCAN_EXIT  = 5'd3;
    localparam upc_t U_MISS       = 5'd4;
    localparam upc_t U_ROOM_CHK   = 5'd5;
    localparam upc_t U_FULL_CHK   = 5'd6;
    localparam upc_t U_APPEND     = 5'd7;
    localparam upc_t U_HIT        = 5'd8;
    localparam upc_t U_REUSE      = 5'd9;
    localparam upc_t U_FREE_EVAL  = 5'd10;
    localparam upc_t U_FREE_APPLY = 5'd11;
    localparam upc_t U_IGNORE     = 5'd12;
    localparam upc_t U_NOHEAP     = 5'd13;
    localparam upc_t U_FULL       = 5'd14;
    localparam upc_t U_UNKNOWN    = 5'd15;
    localparam upc_t U_EMIT       = 5'd16;

    function automatic ucode_t ucode_rom(input upc_t pc);
        ucode_t w;
        w = '{OP_NONE, SEQ_BRANCH, COND_ALWAYS, U_IDLE};
        unique case (pc)
            U_IDLE:       w = '{OP_ACCEPT,      SEQ_WAIT,   COND_ACCEPTED,   U_DISPATCH};
            U_DISPATCH:   w = '{OP_INIT,        SEQ_BRANCH, COND_NULL,       U_IGNORE};
            U_SCAN:       w = '{OP_SCAN,        SEQ_WAIT,   COND_SCAN_DONE,  U_SCAN_EXIT};
            U_SCAN_EXIT:  w = '{OP_NONE,        SEQ_BRANCH, COND_HIT,        U_HIT};
            U_MISS:       w = '{OP_NONE,        SEQ_BRANCH, COND_IS_FREE,    U_UNKNOWN};
            U_ROOM_CHK:   w = '{OP_CALC_TOP,    SEQ_BRANCH, COND_OVER_LIMIT, U_NOHEAP};
            U_FULL_CHK:   w = '{OP_NONE,        SEQ_BRANCH, COND_TABLE_FULL, U_FULL};
            U_APPEND:     w = '{OP_APPEND,      SEQ_BRANCH, COND_ALWAYS,     U_EMIT};
            U_HIT:        w = '{OP_NONE,        SEQ_BRANCH, COND_IS_FREE,    U_FREE_EVAL};
            U_REUSE:      w = '{OP_REUSE,       SEQ_BRANCH, COND_ALWAYS,     U_EMIT};
            U_FREE_EVAL:  w = '{OP_FREE_EVAL,   SEQ_NEXT,   COND_ALWAYS,     U_IDLE};
            U_FREE_APPLY: w = '{OP_FREE_APPLY,  SEQ_BRANCH, COND_ALWAYS,     U_EMIT};
            U_IGNORE:     w = '{OP_RES_IGNORE,  SEQ_BRANCH, COND_ALWAYS,     U_EMIT};
            U_NOHEAP:     w = '{OP_RES_NOHEAP,  SEQ_BRANCH, COND_ALWAYS,     U_EMIT};
            U_FULL:       w = '{OP_RES_FULL,    SEQ_BRANCH, COND_ALWAYS,     U_EMIT};
            U_UNKNOWN:    w = '{OP_RES_UNKNOWN, SEQ_BRANCH, COND_ALWAYS,     U_EMIT};
            U_EMIT:       w = '{OP_EMIT,        SEQ_WAIT,   COND_OUT_FREE,   U_IDLE};
            default:      w = '{OP_NONE,        SEQ_BRANCH, COND_ALWAYS,     U_IDLE};
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    // Block table: payload offset, original size, free mark.
    logic [AW-1:0] off_mem  [MAX_BLOCKS];
    logic [FW-1:0] size_mem [MAX_BLOCKS];
    logic          free_mem [MAX_BLOCKS];

    // Control state (reset)
    upc_t             upc_reg,        upc_next;
    logic [CNT_W-1:0] count_reg,      count_next;
    logic [AW-1:0]    top_reg,        top_next;
    logic             m_valid_reg,    m_valid_next;
    logic [FW-1:0]    heap_limit_reg, heap_limit_next;
    logic [HW-1:0]    hdr_reg,        hdr_next;
    logic             pend_reg,       pend_next;
    logic             hit_reg,        hit_next;

    // Datapath (no reset)
    logic                cmd_reg,       cmd_next;
    logic [FW-1:0]       size_reg,      size_next;
    logic [FW-1:0]       addr_reg,      addr_next;
    logic [CNT_W-1:0]    issue_idx_reg, issue_idx_next;
    logic [IDX_W-1:0]    pend_idx_reg,  pend_idx_next;
    logic [IDX_W-1:0]    hit_idx_reg,   hit_idx_next;
    logic [AW-1:0]       hit_off_reg,   hit_off_next;
    logic [FW-1:0]       hit_size_reg,  hit_size_next;
    logic [AW-1:0]       base_reg,      base_next;
    logic [AW-1:0]       new_top_reg,   new_top_next;
    logic                pop_reg,       pop_next;
    logic [DROP_W-1:0]   drop_reg,      drop_next;
    ffha_pkg::out_item_t res_reg,       res_next;
    ffha_pkg::out_item_t m_data_reg,    m_data_next;

    // Memory read data
    logic [AW-1:0] rd_off_reg;
    logic [FW-1:0] rd_size_reg;
    logic          rd_free_reg;

    // ------------------------------------------------------------------
    // Sequencer and datapath
    // ------------------------------------------------------------------
    ucode_t           cw;
    logic             accepted;
    logic             is_null;
    logic             issue_more;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             hit_now;
    logic             scan_done;
    logic [NT_W-1:0]  new_top_w;
    logic             over_limit;
    logic             table_full;
    logic             out_free;
    logic             cond_true;
    logic             wr_entry;
    logic             wr_free;
    logic             wr_free_val;
    logic [IDX_W-1:0] wr_addr;

    assign cw        = ucode_rom(upc_reg);
    assign s_ready   = (upc_reg == U_IDLE);
    assign accepted  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        is_null    = (cmd_reg == ffha_pkg::CMD_ALLOC) ? (size_reg == '0) : (addr_reg == '0);
        issue_more = (issue_idx_reg != count_reg);
        rd_en      = (cw.op == OP_SCAN) && issue_more;
        rd_addr    = issue_idx_reg[IDX_W-1:0];

        // Compare the entry read in the previous cycle.
        if (cmd_reg == ffha_pkg::CMD_ALLOC) begin
            hit_now = pend_reg && rd_free_reg && (rd_size_reg >= size_reg);
        end else begin
            hit_now = pend_reg && (CW_W'(rd_off_reg) == CW_W'(addr_reg));
        end
        scan_done = hit_now || !issue_more;

        new_top_w  = NT_W'(top_reg) + NT_W'(hdr_reg) + NT_W'(size_reg);
        over_limit = (new_top_w > NT_W'(heap_limit_reg));
        table_full = (count_reg == CNT_W'(MAX_BLOCKS));
        out_free   = !m_valid_reg || m_ready;

        unique case (cw.cond)
            COND_ALWAYS:     cond_true = 1'b1;
            COND_ACCEPTED:   cond_true = accepted;
            COND_NULL:       cond_true = is_null;
            COND_SCAN_DONE:  cond_true = scan_done;
            COND_HIT:        cond_true = hit_reg;
            COND_IS_FREE:    cond_true = (cmd_reg == ffha_pkg::CMD_FREE);
            COND_OVER_LIMIT: cond_true = over_limit;
            COND_TABLE_FULL: cond_true = table_full;
            COND_OUT_FREE:   cond_true = out_free;
            default:         cond_true = 1'b0;
        endcase

        unique case (cw.seq)
            SEQ_NEXT:   upc_next = upc_reg + upc_t'(1);
            SEQ_BRANCH: upc_next = cond_true ? cw.target : upc_reg + upc_t'(1);
            SEQ_WAIT:   upc_next = cond_true ? cw.target : upc_reg;
            default:    upc_next = U_IDLE;
        endcase

        // hold by default
        count_next     = count_reg;
        top_next       = top_reg;
        pend_next      = 1'b0;
        hit_next       = hit_reg;
        cmd_next       = cmd_reg;
        size_next      = size_reg;
        addr_next      = addr_reg;
        issue_idx_next = issue_idx_reg;
        pend_idx_next  = pend_idx_reg;
        hit_idx_next   = hit_idx_reg;
        hit_off_next   = hit_off_reg;
        hit_size_next  = hit_size_reg;
        base_next      = base_reg;
        new_top_next   = new_top_reg;
        pop_next       = pop_reg;
        drop_next      = drop_reg;
        res_next       = res_reg;
        wr_entry       = 1'b0;
        wr_free        = 1'b0;
        wr_free_val    = 1'b0;
        wr_addr        = hit_idx_reg;

        // drain the output register
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (cw.op)
            OP_NONE: begin
            end
            OP_ACCEPT: begin
                if (accepted) begin
                    cmd_next  = s_data.cmd;
                    size_next = s_data.request_size;
                    addr_next = s_data.payload_address;
                end
            end
            OP_INIT: begin
                issue_idx_next = '0;
                hit_next       = 1'b0;
            end
            OP_SCAN: begin
                // issue the next read while checking the previous one
                if (rd_en) begin
                    pend_next      = 1'b1;
                    pend_idx_next  = rd_addr;
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                end
                if (hit_now) begin
                    hit_next      = 1'b1;
                    hit_idx_next  = pend_idx_reg;
                    hit_off_next  = rd_off_reg;
                    hit_size_next = rd_size_reg;
                end
            end
            OP_CALC_TOP: begin
                new_top_next = AW'(new_top_w);
                base_next    = AW'(NT_W'(top_reg) + NT_W'(hdr_reg));
            end
            OP_APPEND: begin
                wr_entry    = 1'b1;
                wr_free     = 1'b1;
                wr_free_val = 1'b0;
                wr_addr     = count_reg[IDX_W-1:0];
                count_next  = count_reg + CNT_W'(1);
                top_next    = new_top_reg;
                res_next    = '{FW'(base_reg), ffha_pkg::STAT_OK, 1'b0};
            end
            OP_REUSE: begin
                wr_free     = 1'b1;
                wr_free_val = 1'b0;
                res_next    = '{FW'(hit_off_reg), ffha_pkg::STAT_OK, 1'b1};
            end
            OP_FREE_EVAL: begin
                // pop only the last block whose payload end meets the top
                pop_next  = ((CNT_W'(hit_idx_reg) + CNT_W'(1)) == count_reg) &&
                            ((NT_W'(hit_off_reg) + NT_W'(hit_size_reg)) == NT_W'(top_reg));
                drop_next = DROP_W'(hdr_reg) + DROP_W'(hit_size_reg);
            end
            OP_FREE_APPLY: begin
                if (pop_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    if (NT_W'(drop_reg) >= NT_W'(top_reg)) begin
                        top_next = '0;
                    end else begin
                        top_next = AW'(NT_W'(top_reg) - NT_W'(drop_reg));
                    end
                end else begin
                    wr_free     = 1'b1;
                    wr_free_val = 1'b1;
                end
                res_next = '{'0, ffha_pkg::STAT_OK, 1'b0};
            end
            OP_RES_IGNORE:  res_next = '{'0, ffha_pkg::STAT_IGNORED, 1'b0};
            OP_RES_NOHEAP:  res_next = '{'0, ffha_pkg::STAT_NO_HEAP, 1'b0};
            OP_RES_FULL:    res_next = '{'0, ffha_pkg::STAT_FULL, 1'b0};
            OP_RES_UNKNOWN: res_next = '{'0, ffha_pkg::STAT_UNKNOWN, 1'b0};
            OP_EMIT: begin
                if (out_free) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // configuration writes
        heap_limit_next = heap_limit_reg;
        hdr_next        = hdr_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == ffha_pkg::REG_HEAP_LIMIT) begin
                heap_limit_next = cfg_data[FW-1:0];
            end else if (cfg_index == ffha_pkg::REG_HEADER_BYTES) begin
                hdr_next = cfg_data[HW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg        <= U_IDLE;
            count_reg      <= '0;
            top_reg        <= '0;
            m_valid_reg    <= 1'b0;
            heap_limit_reg <= ffha_pkg::HEAP_LIMIT_RST;
            hdr_reg        <= ffha_pkg::HEADER_BYTES_RST;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
        end else begin
            upc_reg        <= upc_next;
            count_reg      <= count_next;
            top_reg        <= top_next;
            m_valid_reg    <= m_valid_next;
            heap_limit_reg <= heap_limit_next;
            hdr_reg        <= hdr_next;
            pend_reg       <= pend_next;
            hit_reg        <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        size_reg      <= size_next;
        addr_reg      <= addr_next;
        issue_idx_reg <= issue_idx_next;
        pend_idx_reg  <= pend_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_off_reg   <= hit_off_next;
        hit_size_reg  <= hit_size_next;
        base_reg      <= base_next;
        new_top_reg   <= new_top_next;
        pop_reg       <= pop_next;
        drop_reg      <= drop_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    // Table memory: one write address, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_entry) begin
            off_mem[wr_addr]  <= base_reg;
            size_mem[wr_addr] <= size_reg;
        end
        if (wr_free) begin
            free_mem[wr_addr] <= wr_free_val;
        end
        if (rd_en) begin
            rd_off_reg  <= off_mem[rd_addr];
            rd_size_reg <= size_mem[rd_addr];
            rd_free_reg <= free_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("entry count above table depth");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == U_SCAN) |-> (issue_idx_reg <= count_reg))
        else $error("scan index ran past entry count");

    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(upc_reg == U_EMIT))
        else $error("result raised outside the emit step");

    a_reuse_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.reused) |-> (m_data_reg.status == ffha_pkg::STAT_OK))
        else $error("reused result with failing status");

endmodule
